// File: rtl/pbh_pkg.sv
// Shared types, constants and request codes for the ping-pong buffer handoff core.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps

package pbh_pkg;

  // field and datapath widths
  localparam int RATE_W    = 24;
  localparam int PER_W     = 17;
  localparam int LOAD_W    = 16;
  localparam int FRAME_W   = 11;
  localparam int OVR_W     = 32;
  localparam int REQ_W     = 3;
  localparam int CFG_IDX_W = 2;
  // dividend covers the largest clock plus half the largest rate
  localparam int DIV_W     = 28;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 96;

  // parameter defaults
  localparam int CLOCK_HZ_DEF          = 32000000;
  localparam int FRAMES_PER_BUFFER_DEF = 64;

  // request codes
  localparam logic [REQ_W-1:0] REQ_DONE    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ACQUIRE = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_START   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP    = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE   = 2'd2;

  // configuration reset values
  localparam logic [RATE_W-1:0] FRAME_RATE_RST = 24'd1000;
  localparam logic [RATE_W-1:0] MIN_RATE_RST   = 24'd1;
  localparam logic [RATE_W-1:0] MAX_RATE_RST   = 24'd16000000;

  // period limits and rate saturation
  localparam logic [DIV_W-1:0]  PERIOD_MIN = 28'd2;
  localparam logic [DIV_W-1:0]  PERIOD_MAX = 28'd65536;
  localparam logic [RATE_W-1:0] RATE_SAT   = 24'hFFFFFF;

  // one result item, ready_mask_out in the top bits, ok in bit 0
  typedef struct packed {
    logic [1:0]         ready_mask_out;
    logic               write_index_out;
    logic               rearm;
    logic               running;
    logic [OVR_W-1:0]   overrun_count;
    logic [RATE_W-1:0]  actual_rate_hz;
    logic [LOAD_W-1:0]  timer_load;
    logic [FRAME_W-1:0] frame_count;
    logic               given_index;
    logic               ok;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic exec;          // apply the accepted request directly
    logic div_go;        // launch a division
    logic div_second;    // second division: clock over period
    logic start_reject;  // start failed the period check
    logic start_commit;  // start passed, apply it
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic req_start;
    logic rate_ok;
    logic period_ok;
    logic div_done;
  } status_t;

  function automatic logic [1:0] buf_mask(input logic idx);
    buf_mask = idx ? 2'b10 : 2'b01;
  endfunction

endpackage

// File: rtl/pbh_div.sv
// Restoring divider, one quotient bit per cycle, for the start request.
// Depends on pbh_pkg for widths.
`timescale 1ns / 1ps

module pbh_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [pbh_pkg::DIV_W-1:0]     dividend,
  input  logic [pbh_pkg::RATE_W-1:0]    divisor,
  output logic                          done,
  output logic [pbh_pkg::DIV_W-1:0]     quotient
);

  logic                           busy;
  logic [pbh_pkg::DIV_CNT_W-1:0]  cnt;
  logic [pbh_pkg::RATE_W-1:0]     rem;
  logic [pbh_pkg::RATE_W-1:0]     rem_next;
  logic [pbh_pkg::RATE_W-1:0]     dsr;
  logic [pbh_pkg::RATE_W:0]       rem_sh;
  logic [pbh_pkg::RATE_W:0]       diff;
  logic                           q_bit;

  // one subtract and compare per step
  always_comb begin
    rem_sh   = {rem, quotient[pbh_pkg::DIV_W-1]};
    diff     = rem_sh - {1'b0, dsr};
    q_bit    = (rem_sh >= {1'b0, dsr});
    rem_next = q_bit ? diff[pbh_pkg::RATE_W-1:0] : rem_sh[pbh_pkg::RATE_W-1:0];
  end

  // control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= pbh_pkg::DIV_CNT_W'(pbh_pkg::DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == pbh_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out as quotient bits shift in; divisor held for the whole pass
  always_ff @(posedge clk) begin
    if (go) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[pbh_pkg::DIV_W-2:0], q_bit};
      rem      <= rem_next;
    end
  end

endmodule

// File: rtl/pbh_ctrl.sv
// Sequencer for the handoff core: accepts requests and steps an accepted-rate start
// through up to two divisions. Depends on pbh_pkg for the command and status types.
`timescale 1ns / 1ps

module pbh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  pbh_pkg::status_t status,
  output pbh_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV1 = 2'd1;
  localparam logic [1:0] S_DIV2 = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign s_tready = (state == S_IDLE) && status.out_free;
  assign accept   = s_tvalid && s_tready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (status.req_start && status.rate_ok) begin
            cmd.div_go = 1'b1;
            state_next = S_DIV1;
          end else begin
            cmd.exec = 1'b1;
          end
        end
      end
      S_DIV1: begin
        if (status.div_done) begin
          if (status.period_ok) begin
            cmd.div_go     = 1'b1;
            cmd.div_second = 1'b1;
            state_next     = S_DIV2;
          end else begin
            cmd.start_reject = 1'b1;
            state_next       = S_IDLE;
          end
        end
      end
      S_DIV2: begin
        if (status.div_done) begin
          cmd.start_commit = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/pbh_datapath.sv
// Buffer ownership state, configuration registers, divider and result register.
// Depends on pbh_pkg and pbh_div.
`timescale 1ns / 1ps

module pbh_datapath #(
  parameter int CLOCK_HZ          = pbh_pkg::CLOCK_HZ_DEF,
  parameter int FRAMES_PER_BUFFER = pbh_pkg::FRAMES_PER_BUFFER_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [pbh_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pbh_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [pbh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbh_pkg::RATE_W-1:0]        cfg_data,
  input  pbh_pkg::cmd_t                     cmd,
  output pbh_pkg::status_t                  status
);

  localparam logic [pbh_pkg::DIV_W-1:0] ClockDiv = pbh_pkg::DIV_W'(CLOCK_HZ);

  // configuration
  logic [pbh_pkg::RATE_W-1:0] frame_rate;
  logic [pbh_pkg::RATE_W-1:0] min_rate;
  logic [pbh_pkg::RATE_W-1:0] max_rate;

  // ownership state
  logic                       write_buffer, write_buffer_next;
  logic [1:0]                 ready_bits, ready_bits_next;
  logic [1:0]                 held_bits, held_bits_next;
  logic [pbh_pkg::OVR_W-1:0]  overruns, overruns_next;
  logic [pbh_pkg::RATE_W-1:0] actual_rate, actual_rate_next;
  logic                       is_running, is_running_next;
  logic [pbh_pkg::PER_W-1:0]  period;

  // request fields
  logic [pbh_pkg::REQ_W-1:0]  req_type;
  logic                       buffer_index;

  // divider
  logic [pbh_pkg::DIV_W-1:0]  div_dividend;
  logic [pbh_pkg::RATE_W-1:0] div_divisor;
  logic                       div_done;
  logic [pbh_pkg::DIV_W-1:0]  div_quo;

  pbh_pkg::result_t res, res_next;
  logic             load_res;
  logic             done_buf;
  logic             nxt_buf;
  logic [1:0]       nxt_mask;

  assign req_type     = s_tdata[pbh_pkg::REQ_W-1:0];
  assign buffer_index = s_tdata[pbh_pkg::REQ_W];

  // configuration writes; an index past the list is ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rate <= pbh_pkg::FRAME_RATE_RST;
      min_rate   <= pbh_pkg::MIN_RATE_RST;
      max_rate   <= pbh_pkg::MAX_RATE_RST;
    end else if (cfg_we) begin
      if (cfg_index == pbh_pkg::REG_FRAME_RATE) frame_rate <= cfg_data;
      if (cfg_index == pbh_pkg::REG_MIN_RATE)   min_rate   <= cfg_data;
      if (cfg_index == pbh_pkg::REG_MAX_RATE)   max_rate   <= cfg_data;
    end
  end

  // divider operands: rounded clock over rate, then clock over period
  always_comb begin
    if (cmd.div_second) begin
      div_dividend = ClockDiv;
      div_divisor  = div_quo[pbh_pkg::RATE_W-1:0];
    end else begin
      div_dividend = ClockDiv + pbh_pkg::DIV_W'(frame_rate >> 1);
      div_divisor  = frame_rate;
    end
  end

  pbh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // status towards the sequencer
  always_comb begin
    status.out_free  = !m_tvalid || m_tready;
    status.req_start = (req_type == pbh_pkg::REQ_START);
    status.rate_ok   = (frame_rate != '0) && (frame_rate >= min_rate) &&
                       (frame_rate <= max_rate);
    status.period_ok = (div_quo >= pbh_pkg::PERIOD_MIN) &&
                       (div_quo <= pbh_pkg::PERIOD_MAX);
    status.div_done  = div_done;
  end

  // state update and result assembly
  always_comb begin
    write_buffer_next = write_buffer;
    ready_bits_next   = ready_bits;
    held_bits_next    = held_bits;
    overruns_next     = overruns;
    actual_rate_next  = actual_rate;
    is_running_next   = is_running;
    done_buf          = write_buffer;
    nxt_buf           = ~write_buffer;
    nxt_mask          = pbh_pkg::buf_mask(~write_buffer);
    res_next          = '0;

    if (cmd.exec) begin
      unique case (req_type)
        pbh_pkg::REQ_DONE: begin
          if (is_running) begin
            if ((held_bits & nxt_mask) != 2'b00) begin
              // consumer still holds the other buffer: rewrite this one
              overruns_next = overruns + 1'b1;
              nxt_buf       = done_buf;
            end else begin
              // other buffer unclaimed: drop it
              if ((ready_bits & nxt_mask) != 2'b00) begin
                overruns_next = overruns + 1'b1;
              end
              ready_bits_next = (ready_bits & ~nxt_mask) | pbh_pkg::buf_mask(done_buf);
            end
            write_buffer_next = nxt_buf;
            res_next.rearm    = 1'b1;
          end
        end
        pbh_pkg::REQ_ACQUIRE: begin
          if (ready_bits != 2'b00) begin
            ready_bits_next      = ready_bits & ~pbh_pkg::buf_mask(~ready_bits[0]);
            held_bits_next       = held_bits | pbh_pkg::buf_mask(~ready_bits[0]);
            res_next.ok          = 1'b1;
            res_next.given_index = ~ready_bits[0];
            res_next.frame_count = pbh_pkg::FRAME_W'(FRAMES_PER_BUFFER);
          end
        end
        pbh_pkg::REQ_RELEASE: begin
          held_bits_next = held_bits & ~pbh_pkg::buf_mask(buffer_index);
        end
        pbh_pkg::REQ_STOP: begin
          is_running_next = 1'b0;
        end
        default: begin
          // rejected start or unknown code: status only
        end
      endcase
    end else if (cmd.start_commit) begin
      write_buffer_next   = 1'b0;
      ready_bits_next     = 2'b00;
      held_bits_next      = 2'b00;
      overruns_next       = '0;
      actual_rate_next    = (div_quo > pbh_pkg::DIV_W'(pbh_pkg::RATE_SAT)) ?
                            pbh_pkg::RATE_SAT : div_quo[pbh_pkg::RATE_W-1:0];
      is_running_next     = 1'b1;
      res_next.ok         = 1'b1;
      res_next.rearm      = 1'b1;
      res_next.timer_load = pbh_pkg::LOAD_W'(period - 1'b1);
    end

    res_next.actual_rate_hz  = actual_rate_next;
    res_next.overrun_count   = overruns_next;
    res_next.running         = is_running_next;
    res_next.write_index_out = write_buffer_next;
    res_next.ready_mask_out  = ready_bits_next;
  end

  assign load_res = cmd.exec || cmd.start_reject || cmd.start_commit;

  // ownership state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_buffer <= 1'b0;
      ready_bits   <= 2'b00;
      held_bits    <= 2'b00;
      overruns     <= '0;
      actual_rate  <= '0;
      is_running   <= 1'b0;
    end else begin
      write_buffer <= write_buffer_next;
      ready_bits   <= ready_bits_next;
      held_bits    <= held_bits_next;
      overruns     <= overruns_next;
      actual_rate  <= actual_rate_next;
      is_running   <= is_running_next;
    end
  end

  // period kept for the timer reload value
  always_ff @(posedge clk) begin
    if (cmd.div_second) begin
      period <= div_quo[pbh_pkg::PER_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_res) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      res <= res_next;
    end
  end

  assign m_tdata = {(pbh_pkg::OUT_DATA_W - $bits(pbh_pkg::result_t))'(0), res};

endmodule

// File: rtl/ping_pong_buffer_handoff_core.sv
// Top level of the ping-pong buffer handoff core: sequencer plus datapath.
// Depends on pbh_pkg, pbh_ctrl, pbh_datapath (and pbh_div below it).
//
// Usage:
//   Requests arrive on the s_ group (buffer done, acquire, release, start,
//   stop); every request gives exactly one result transaction on the m_ group
//   carrying the handoff outcome and the full status after the request.
//   Rate registers are written through cfg_we/cfg_index/cfg_data while idle.
// Sequencing:
//   buffer done, acquire, release, stop and a start refused on its rate limits
//   answer in the cycle after acceptance. An accepted-rate start runs two
//   passes of a shared 28-step restoring divider (rounded period, then
//   achieved rate), the second only when the period lies in 2..65536.
//   One request is in flight at a time.
// Reset:
//   rst is synchronous, active high; clears all buffer ownership, the overrun
//   counter, achieved rate and running flag, and restores the rate registers.
// Backpressure:
//   the result waits in the output register while m_tready is low; a new request
//   is taken once that register is free or draining and the sequencer is idle.
`timescale 1ns / 1ps

module ping_pong_buffer_handoff_core #(
  parameter int CLOCK_HZ          = pbh_pkg::CLOCK_HZ_DEF,
  parameter int FRAMES_PER_BUFFER = pbh_pkg::FRAMES_PER_BUFFER_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [2:0] req_type, [3] buffer_index, [7:4] zero
  input  logic [pbh_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] ok, [1] given_index, [12:2] frame_count, [28:13] timer_load,
  // [52:29] actual_rate_hz, [84:53] overrun_count, [85] running, [86] rearm,
  // [87] write_index_out, [89:88] ready_mask_out, [95:90] zero
  output logic [pbh_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [pbh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbh_pkg::RATE_W-1:0]        cfg_data
);

  pbh_pkg::cmd_t    cmd;
  pbh_pkg::status_t status;
  pbh_pkg::result_t out_res;

  pbh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pbh_datapath #(
    .CLOCK_HZ          (CLOCK_HZ),
    .FRAMES_PER_BUFFER (FRAMES_PER_BUFFER)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  assign out_res = m_tdata[$bits(pbh_pkg::result_t)-1:0];

  // no request is taken while the divider is finishing a pass
  a_no_accept_on_div_done: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> !(s_tvalid && s_tready))
    else $error("request accepted while a start division was completing");

  // a division launch never coincides with a directly executed request
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.exec, cmd.div_go, cmd.start_commit, cmd.start_reject}) <= 1)
    else $error("conflicting datapath commands");

  // the buffer under DMA is never offered to the consumer
  a_write_not_ready: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_res.ready_mask_out &
                   pbh_pkg::buf_mask(out_res.write_index_out)) == 2'b00))
    else $error("write buffer marked ready");

  // a timer reload value only comes with an accepted start
  a_load_with_start: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_res.timer_load != '0)) |->
      (out_res.ok && out_res.running && out_res.rearm))
    else $error("timer reload value without an accepted start");

endmodule
